/* hw/rtl/plic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_pkg: shared types and codes of the piecewise linear interpolator
// Holds the token that travels down the knot cell chain and the status codes.
// ----------------------------------------------------------------------------
package plic_pkg;

    // Number of knot cells; the slot and segment fields are sized for it.
    localparam int KNOTS = 16;

    // Status codes of a result.
    localparam logic [2:0] ST_INSIDE = 3'd0;
    localparam logic [2:0] ST_BELOW  = 3'd1;
    localparam logic [2:0] ST_ABOVE  = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_ZERO_W = 3'd4;

    // Input item kinds.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [7:0] CFG_KNOT_COUNT = 8'd0;
    localparam logic [7:0] CFG_ANGLE_MODE = 8'd1;

    // Query token handed from cell to cell.
    typedef struct packed {
        logic        valid;
        logic        done;
        logic        hint_mode;
        logic [3:0]  s_hint;
        logic [4:0]  seg;
        logic        right;
        logic [31:0] q;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [31:0] v0;
        logic [31:0] v1;
    } t_token;

endpackage

/* hw/rtl/plic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_cell: one breakpoint cell of the chain
// Stores one knot and checks the passing query token against its segment.
// ----------------------------------------------------------------------------
module plic_cell #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [3:0]        i_wr_slot,
    input  logic [31:0]       i_wr_time,
    input  logic [31:0]       i_wr_value,
    input  logic [4:0]        i_n,
    input  logic [31:0]       i_nb_time,
    input  logic [31:0]       i_nb_value,
    output logic [31:0]       o_time,
    output logic [31:0]       o_value,
    input  plic_pkg::t_token  i_tok,
    output plic_pkg::t_token  o_tok
);

    localparam logic [8:0] IDX9 = 9'(IDX);

    logic [31:0]      r_time;
    logic [31:0]      r_value;
    plic_pkg::t_token r_tok;
    plic_pkg::t_token n_tok;
    logic [8:0]       w_n9;
    logic             w_active;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (IDX9 == {5'b0, i_wr_slot})) begin
            r_time  <= i_wr_time;
            r_value <= i_wr_value;
        end
    end

    assign w_n9     = {4'b0, i_n};
    assign w_active = i_tok.valid && !i_tok.done && ((IDX9 + 9'd1) < w_n9);

    always_comb begin
        logic hit;
        hit   = 1'b0;
        n_tok = i_tok;
        if (w_active) begin
            if (i_tok.hint_mode) begin
                hit = (IDX9 == {5'b0, i_tok.s_hint});
            end else if ((IDX == 0) && ($signed(i_tok.q) < $signed(r_time))) begin
                hit         = 1'b1;
                n_tok.seg   = 5'h1F;
                n_tok.right = 1'b0;
            end else if (($signed(r_time) <= $signed(i_tok.q)) &&
                         ($signed(i_tok.q) < $signed(i_nb_time))) begin
                hit         = 1'b1;
                n_tok.seg   = 5'(IDX);
                n_tok.right = 1'b0;
            end else if ((IDX9 + 9'd2) == w_n9) begin
                // Nothing matched: the query lies on or past the last knot.
                hit         = 1'b1;
                n_tok.seg   = 5'(IDX + 1);
                n_tok.right = 1'b1;
            end
            if (hit) begin
                n_tok.done = 1'b1;
                n_tok.t0   = r_time;
                n_tok.t1   = i_nb_time;
                n_tok.v0   = r_value;
                n_tok.v1   = i_nb_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_time  = r_time;
    assign o_value = r_value;
    assign o_tok   = r_tok;

endmodule

/* hw/rtl/plic_wrap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_wrap: serial angle wrap into [-pi, pi)
// Reduces one signed value modulo two pi, one remainder bit per cycle.
// ----------------------------------------------------------------------------
module plic_wrap #(
    parameter logic [33:0] PI_Q = 34'd205888
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [34:0] i_x,
    output logic               o_done,
    output logic [31:0]        o_result
);

    localparam logic [34:0] TWO_PI = {PI_Q, 1'b0};

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [33:0] r_mag;
    logic [34:0] r_rem;
    logic [31:0] r_result;
    logic signed [34:0] w_y;
    logic [34:0] w_rem2;
    logic [34:0] w_rem_n;
    logic [34:0] w_mod;

    assign w_y     = i_x + $signed({1'b0, PI_Q});
    assign w_rem2  = {r_rem[33:0], r_mag[33]};
    assign w_rem_n = (w_rem2 >= TWO_PI) ? (w_rem2 - TWO_PI) : w_rem2;
    assign w_mod   = (r_neg && (w_rem_n != 35'd0)) ? (TWO_PI - w_rem_n) : w_rem_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_neg  <= w_y[34];
                r_mag  <= w_y[34] ? 34'(-w_y) : w_y[33:0];
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_rem_n;
                r_mag <= {r_mag[32:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                    r_result <= 32'(w_mod - {1'b0, PI_Q});
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* hw/rtl/plic_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plic_divider: serial restoring divider
// Divides a 64-bit magnitude by a 32-bit one, keeping a capped quotient and
// the quotient modulo two pi.
// ----------------------------------------------------------------------------
module plic_divider #(
    parameter logic [33:0] PI_Q = 34'd205888
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [40:0] o_qcap,
    output logic [31:0] o_qmod
);

    localparam logic [32:0] TWO_PI = 33'({PI_Q, 1'b0});
    localparam logic [41:0] CAP    = 42'd1 << 40;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [31:0] r_div;
    logic [31:0] r_rem;
    logic [40:0] r_qcap;
    logic [31:0] r_qmod;
    logic [32:0] w_rem2;
    logic        w_qb;
    logic [41:0] w_c2;
    logic [32:0] w_m2;

    assign w_rem2 = {r_rem, r_num[63]};
    assign w_qb   = (w_rem2 >= {1'b0, r_div});
    assign w_c2   = {r_qcap, w_qb};
    assign w_m2   = {r_qmod, w_qb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_qcap <= '0;
                r_qmod <= '0;
            end else if (r_busy) begin
                r_rem  <= w_qb ? 32'(w_rem2 - {1'b0, r_div}) : w_rem2[31:0];
                r_num  <= {r_num[62:0], 1'b0};
                r_qcap <= (w_c2 > CAP) ? CAP[40:0] : w_c2[40:0];
                r_qmod <= (w_m2 >= TWO_PI) ? 32'(w_m2 - TWO_PI) : w_m2[31:0];
                r_cnt  <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_qcap = r_qcap;
    assign o_qmod = r_qmod;

endmodule

/* hw/rtl/piecewise_linear_interp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interp: Q16.16 piecewise linear interpolator
// A chain of knot cells locates the segment; a serial divider and a shared
// serial angle wrap unit produce the interpolated or extrapolated value.
// ----------------------------------------------------------------------------
// A breakpoint write is stored when it is accepted. With no knots a
// query goes through S_OUT to the output register, with one knot also through
// one wrap pass in angle mode; else the token walks all KNOTS cells, then the
// 64-step divider (not at zero width) and, in angle mode, 34-step wrap passes.
// Throughput: one query at a time; a new item is taken while a result waits.
// Reset (synchronous, active low) clears knot_count, angle_mode and control.
module piecewise_linear_interp #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: knot_slot[3:0], knot_time[35:4], knot_value[67:36],
    // query_time[99:68], use_hint[100], hint_segment[105:101], zeros above.
    input  logic [111:0] s_axis_tdata,
    // tuser: op
    input  logic         s_axis_tuser,
    // Output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: result_value[31:0], segment_index[36:32],
    // status[39:37], saturated[40], zeros above.
    output logic [47:0]  m_axis_tdata,
    // Configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int KNOTS = plic_pkg::KNOTS;

    // pi scaled by 2^FRAC_BITS, rounded to nearest.
    localparam longint      PI_L = (64'd13493037705 + (64'd1 << (31 - FRAC_BITS)))
                                   >> (32 - FRAC_BITS);
    localparam logic [33:0] PI_Q = 34'(PI_L);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHAIN = 4'd1;
    localparam logic [3:0] S_CALC  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DIVST = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_FIN   = 4'd6;
    localparam logic [3:0] S_WRAP  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // Input fields.
    logic        w_op;
    logic [3:0]  w_slot;
    logic [31:0] w_ktime;
    logic [31:0] w_kvalue;
    logic [31:0] w_qtime;
    logic        w_use_hint;
    logic [4:0]  w_hint;

    assign w_op       = s_axis_tuser;
    assign w_slot     = s_axis_tdata[3:0];
    assign w_ktime    = s_axis_tdata[35:4];
    assign w_kvalue   = s_axis_tdata[67:36];
    assign w_qtime    = s_axis_tdata[99:68];
    assign w_use_hint = s_axis_tdata[100];
    assign w_hint     = s_axis_tdata[105:101];

    logic        r_angle;
    logic [4:0]  r_count;
    logic [3:0]  r_state;
    logic        w_in_acc;
    logic [4:0]  w_n;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    // The count is capped at the number of cells.
    assign w_n = ({27'b0, r_count} > 32'(KNOTS)) ? 5'(KNOTS) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_angle <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                plic_pkg::CFG_KNOT_COUNT: r_count <= i_cfg_data[4:0];
                plic_pkg::CFG_ANGLE_MODE: r_angle <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Knot cell chain. Each cell but the last sees its right neighbor's
    // knot, and the query token moves one cell per cycle.
    // ------------------------------------------------------------------
    logic [31:0]      w_ctime  [KNOTS];
    logic [31:0]      w_cvalue [KNOTS];
    plic_pkg::t_token w_tok    [KNOTS+1];
    plic_pkg::t_token r_inj;
    logic             w_wr_en;
    logic             w_inject;

    assign w_wr_en  = w_in_acc && (w_op == plic_pkg::OP_WRITE);
    // A query with two or more knots enters the chain.
    assign w_inject = w_in_acc && (w_op == plic_pkg::OP_QUERY) && (w_n > 5'd1);
    assign w_tok[0] = r_inj;

    for (genvar g = 0; g < KNOTS; g++) begin : g_cell
        plic_cell #(.IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_wr_en),
            .i_wr_slot  (w_slot),
            .i_wr_time  (w_ktime),
            .i_wr_value (w_kvalue),
            .i_n        (w_n),
            .i_nb_time  (w_ctime[(g + 1 < KNOTS) ? g + 1 : g]),
            .i_nb_value (w_cvalue[(g + 1 < KNOTS) ? g + 1 : g]),
            .o_time     (w_ctime[g]),
            .o_value    (w_cvalue[g]),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    // Hint clamped to -1 .. n-1 and turned into the slope segment.
    logic signed [5:0] w_h6;
    logic signed [5:0] w_nm1;
    logic signed [5:0] w_segh;
    logic [3:0]        w_sh;

    assign w_h6  = $signed({w_hint[4], w_hint});
    assign w_nm1 = $signed({1'b0, w_n}) - 6'sd1;
    assign w_segh = (w_h6 < -6'sd1) ? -6'sd1 : ((w_h6 > w_nm1) ? w_nm1 : w_h6);
    assign w_sh  = (w_segh < 6'sd0) ? 4'd0 :
                   ((w_segh == w_nm1) ? 4'(w_nm1 - 6'sd1) : w_segh[3:0]);

    // ------------------------------------------------------------------
    // Arithmetic datapath.
    // ------------------------------------------------------------------
    logic [31:0]        r_q;
    logic [4:0]         r_seg;
    logic [2:0]         r_status;
    logic               r_right;
    logic [31:0]        r_t0, r_t1, r_v0, r_v1;
    logic signed [32:0] r_dv;
    logic signed [32:0] r_dt;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [31:0]        r_dabs;
    logic [40:0]        r_qcap;
    logic [31:0]        r_qmod;
    logic [31:0]        r_res;
    logic               r_sat;
    logic               r_wrap_dv;
    logic               r_ovalid;
    logic [47:0]        r_odata;

    logic [31:0]        w_ta, w_va;
    logic signed [32:0] w_dt, w_dvl, w_dq;
    logic [31:0]        w_dq_abs, w_dv_abs;
    logic signed [41:0] w_sum;
    logic signed [41:0] w_qs;
    logic signed [34:0] w_afin;
    logic               w_out_load;

    assign w_ta     = r_right ? r_t1 : r_t0;
    assign w_va     = r_right ? r_v1 : r_v0;
    assign w_dt     = $signed({r_t1[31], r_t1}) - $signed({r_t0[31], r_t0});
    assign w_dvl    = $signed({r_v1[31], r_v1}) - $signed({r_v0[31], r_v0});
    assign w_dq     = $signed({r_q[31], r_q}) - $signed({w_ta[31], w_ta});
    assign w_dq_abs = w_dq[32] ? 32'(-w_dq) : w_dq[31:0];
    assign w_dv_abs = r_dv[32] ? 32'(-r_dv) : r_dv[31:0];
    assign w_qs     = r_neg ? -$signed({1'b0, r_qcap}) : $signed({1'b0, r_qcap});
    assign w_sum    = $signed({{10{w_va[31]}}, w_va}) + w_qs;
    assign w_afin   = r_neg ? ($signed({{3{w_va[31]}}, w_va}) - $signed({3'b0, r_qmod}))
                            : ($signed({{3{w_va[31]}}, w_va}) + $signed({3'b0, r_qmod}));
    // The finished result moves into the output register once it is free.
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    // Shared wrap unit operand selection.
    logic               w_wstart;
    logic signed [34:0] w_wx;
    logic               w_wdone;
    logic [31:0]        w_wres;

    always_comb begin
        w_wstart = 1'b0;
        w_wx     = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (w_op == plic_pkg::OP_QUERY) && (w_n == 5'd1) && r_angle) begin
                    w_wstart = 1'b1;
                    w_wx     = $signed({{3{w_cvalue[0][31]}}, w_cvalue[0]});
                end
            end
            S_CALC: begin
                if (r_angle) begin
                    w_wstart = 1'b1;
                    w_wx     = (w_dt == 33'sd0) ? $signed({{3{w_va[31]}}, w_va})
                                                : $signed({{2{w_dvl[32]}}, w_dvl});
                end
            end
            S_FIN: begin
                if (r_angle) begin
                    w_wstart = 1'b1;
                    w_wx     = w_afin;
                end
            end
            default: ;
        endcase
    end

    plic_wrap #(.PI_Q(PI_Q)) u_wrap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_wstart),
        .i_x      (w_wx),
        .o_done   (w_wdone),
        .o_result (w_wres)
    );

    logic        w_ddone;
    logic [40:0] w_qcap;
    logic [31:0] w_qmod;

    plic_divider #(.PI_Q(PI_Q)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVST),
        .i_dividend (r_prod),
        .i_divisor  (r_dabs),
        .o_done     (w_ddone),
        .o_qcap     (w_qcap),
        .o_qmod     (w_qmod)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inj    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_inj.valid <= w_inject;
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (w_op == plic_pkg::OP_QUERY)) begin
                        r_q   <= w_qtime;
                        r_sat <= 1'b0;
                        if (w_n == 5'd0) begin
                            r_res    <= '0;
                            r_seg    <= 5'h1F;
                            r_status <= plic_pkg::ST_EMPTY;
                            r_state  <= S_OUT;
                        end else if (w_n == 5'd1) begin
                            // A single knot gives its own value, wrapped in angle mode.
                            r_res <= w_cvalue[0];
                            if ($signed(w_qtime) < $signed(w_ctime[0])) begin
                                r_seg    <= 5'h1F;
                                r_status <= plic_pkg::ST_BELOW;
                            end else begin
                                r_seg    <= 5'd0;
                                r_status <= plic_pkg::ST_ABOVE;
                            end
                            r_wrap_dv <= 1'b0;
                            r_state   <= r_angle ? S_WRAP : S_OUT;
                        end else begin
                            r_inj.done      <= 1'b0;
                            r_inj.hint_mode <= w_use_hint;
                            r_inj.s_hint    <= w_sh;
                            r_inj.seg       <= 5'(w_segh);
                            r_inj.right     <= (w_segh == w_nm1);
                            r_inj.q         <= w_qtime;
                            r_state         <= S_CHAIN;
                        end
                    end
                end
                S_CHAIN: begin
                    if (w_tok[KNOTS].valid) begin
                        r_seg   <= w_tok[KNOTS].seg;
                        r_right <= w_tok[KNOTS].right;
                        r_t0    <= w_tok[KNOTS].t0;
                        r_t1    <= w_tok[KNOTS].t1;
                        r_v0    <= w_tok[KNOTS].v0;
                        r_v1    <= w_tok[KNOTS].v1;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_dt <= w_dt;
                    if (r_seg[4]) begin
                        r_status <= plic_pkg::ST_BELOW;
                    end else if (r_right) begin
                        r_status <= plic_pkg::ST_ABOVE;
                    end else begin
                        r_status <= plic_pkg::ST_INSIDE;
                    end
                    if (w_dt == 33'sd0) begin
                        // Zero width: anchor knot's value, wrapped in angle mode.
                        r_res     <= w_va;
                        r_status  <= plic_pkg::ST_ZERO_W;
                        r_wrap_dv <= 1'b0;
                        r_state   <= r_angle ? S_WRAP : S_OUT;
                    end else begin
                        r_dv      <= w_dvl;
                        r_wrap_dv <= 1'b1;
                        r_state   <= r_angle ? S_WRAP : S_MUL;
                    end
                end
                S_MUL: begin
                    r_neg   <= w_dq[32] ^ r_dv[32] ^ r_dt[32];
                    r_prod  <= w_dq_abs * w_dv_abs;
                    r_dabs  <= r_dt[32] ? 32'(-r_dt) : r_dt[31:0];
                    r_state <= S_DIVST;
                end
                S_DIVST: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_qcap  <= w_qcap;
                        r_qmod  <= w_qmod;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_angle) begin
                        r_wrap_dv <= 1'b0;
                        r_state   <= S_WRAP;
                    end else begin
                        if (w_sum > 42'sh7FFFFFFF) begin
                            r_res <= 32'h7FFFFFFF;
                            r_sat <= 1'b1;
                        end else if (w_sum < -42'sh80000000) begin
                            r_res <= 32'h80000000;
                            r_sat <= 1'b1;
                        end else begin
                            r_res <= w_sum[31:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_WRAP: begin
                    if (w_wdone) begin
                        if (r_wrap_dv) begin
                            r_dv    <= $signed({w_wres[31], w_wres});
                            r_state <= S_MUL;
                        end else begin
                            r_res   <= w_wres;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    // The output register frees the sequencer for the next item.
                    if (w_out_load) begin
                        r_odata  <= {7'b0, r_sat, r_status, r_seg, r_res};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the piecewise linear interpolator
// A directed table followed by random phases drives breakpoint writes and
// queries through the input stream and registers through the config channel.
// Each query result is predicted or set by its row and compared field by field.
// ----------------------------------------------------------------------------
module tb;

    // Pi and two pi in Q16.16, pi rounded to nearest.
    localparam longint PI_Q     = 64'sd205887;
    localparam longint TWO_PI_Q = 2 * PI_Q;
    localparam int     SETTLE_CYCLES = 300;

    typedef struct {
        logic        op;
        logic [3:0]  slot;
        logic [31:0] ktime;
        logic [31:0] kval;
        logic [31:0] qtime;
        logic        use_hint;
        logic [4:0]  hint;
    } t_plan_item;

    typedef struct {
        logic [31:0] value;
        logic [4:0]  seg;
        logic [2:0]  status;
        logic        sat;
    } t_interp;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // A directed row is either a register write or an item; typed rows carry
    // their expected result instead of asking the predictor.
    typedef struct {
        t_row_kind   kind;
        logic [7:0]  cfg_idx;
        logic [31:0] cfg_data;
        t_plan_item  it;
        bit          typed;
        t_interp     res;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    piecewise_linear_interp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the breakpoint table and the registers, kept sign-extended.
    longint  knot_t [16];
    longint  knot_v [16];
    int      knot_count = 0;
    bit      angle_on = 1'b0;

    t_interp expected_q[$];
    int      mismatches = 0;
    int      tx_max = 5;
    int      rx_max = 5;
    int      long_hold_req = 0;

    function automatic longint wrap_pi(input longint x);
        longint m;
        m = (x + PI_Q) % TWO_PI_Q;
        if (m < 0) m += TWO_PI_Q;
        return m - PI_Q;
    endfunction

    function automatic logic [63:0] mag(input longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    // Expected result of one query against the shadow table.
    function automatic t_interp interpolate(input t_plan_item it);
        longint      q, n, seg, a, s, dt, dv, dq, h, res, qmod;
        logic [127:0] prod, quo;
        logic [63:0] qcap;
        logic        neg;
        t_interp     r;
        q = longint'($signed(it.qtime));
        n = (knot_count > 16) ? 16 : knot_count;
        r.sat = 1'b0;
        if (n == 0) begin
            res = 0;
            seg = -1;
            r.status = plic_pkg::ST_EMPTY;
        end else if (n == 1) begin
            res = angle_on ? wrap_pi(knot_v[0]) : knot_v[0];
            seg = (q < knot_t[0]) ? -1 : 0;
            r.status = (seg < 0) ? plic_pkg::ST_BELOW : plic_pkg::ST_ABOVE;
        end else begin
            if (it.use_hint) begin
                h = longint'($signed(it.hint));
                seg = (h < -1) ? -1 : ((h > n - 1) ? n - 1 : h);
            end else if (q < knot_t[0]) begin
                seg = -1;
            end else begin
                seg = n - 1;
                for (int i = 0; i < n - 1; i++) begin
                    if (knot_t[i] <= q && q < knot_t[i + 1]) begin
                        seg = i;
                        break;
                    end
                end
            end
            if (seg < 0) begin
                a = 0; s = 0; r.status = plic_pkg::ST_BELOW;
            end else if (seg == n - 1) begin
                a = n - 1; s = n - 2; r.status = plic_pkg::ST_ABOVE;
            end else begin
                a = seg; s = seg; r.status = plic_pkg::ST_INSIDE;
            end
            dt = knot_t[s + 1] - knot_t[s];
            if (dt == 0) begin
                res = angle_on ? wrap_pi(knot_v[a]) : knot_v[a];
                r.status = plic_pkg::ST_ZERO_W;
            end else begin
                dv = knot_v[s + 1] - knot_v[s];
                if (angle_on) dv = wrap_pi(dv);
                dq = q - knot_t[a];
                neg = (dq < 0) ^ (dv < 0) ^ (dt < 0);
                prod = 128'(mag(dq)) * 128'(mag(dv));
                quo = prod / 128'(mag(dt));
                // The quotient only matters up to 2^40 in linear mode.
                qcap = (quo > 128'h100_0000_0000) ? 64'h100_0000_0000 : quo[63:0];
                qmod = longint'(quo % 128'(TWO_PI_Q));
                if (angle_on) begin
                    res = wrap_pi(knot_v[a] + (neg ? -qmod : qmod));
                end else begin
                    res = knot_v[a] + (neg ? -longint'(qcap) : longint'(qcap));
                    if (res > 64'sd2147483647) begin
                        res = 64'sd2147483647;
                        r.sat = 1'b1;
                    end else if (res < -64'sd2147483648) begin
                        res = -64'sd2147483648;
                        r.sat = 1'b1;
                    end
                end
            end
        end
        r.value = res[31:0];
        r.seg = seg[4:0];
        return r;
    endfunction

    // Sends one item; the shadow state and the expected results follow the
    // transaction at the edge where it is accepted.
    task automatic send_item(input t_plan_item it, input bit typed, input t_interp res);
        repeat ($urandom_range(0, tx_max)) @(negedge i_clk);
        s_axis_tdata = {6'b0, it.hint, it.use_hint, it.qtime, it.kval, it.ktime, it.slot};
        s_axis_tuser = it.op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (it.op == plic_pkg::OP_WRITE) begin
            knot_t[it.slot] = longint'($signed(it.ktime));
            knot_v[it.slot] = longint'($signed(it.kval));
        end else begin
            expected_q.push_back(typed ? res : interpolate(it));
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == plic_pkg::CFG_KNOT_COUNT) knot_count = int'(data[4:0]);
        else if (idx == plic_pkg::CFG_ANGLE_MODE) angle_on = data[0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Waits until every expected result has come, then lets a write that may
    // still be in flight finish before any register is touched.
    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_plan_item knot_wr(input int slot, input logic [31:0] t,
                                           input logic [31:0] v);
        t_plan_item it;
        it = '{plic_pkg::OP_WRITE, slot[3:0], t, v, $urandom, 1'b0, 5'($urandom)};
        return it;
    endfunction

    function automatic t_plan_item query(input logic [31:0] q, input logic uh,
                                         input logic [4:0] h);
        t_plan_item it;
        it = '{plic_pkg::OP_QUERY, 4'($urandom), $urandom, $urandom, q, uh, h};
        return it;
    endfunction

    // Receiver: draws a stall per result; a long hold-off request from the
    // main flow is counted out here so the block backs up into its input.
    initial begin
        int      stall;
        t_interp got, want;
        forever begin
            stall = $urandom_range(0, rx_max);
            if (long_hold_req > 0) begin
                stall = long_hold_req;
                long_hold_req = 0;
            end
            @(negedge i_clk);
            m_axis_tready = (stall == 0);
            repeat (stall) @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = '{m_axis_tdata[31:0], m_axis_tdata[36:32], m_axis_tdata[39:37],
                    m_axis_tdata[40]};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h seg %0d status %0d sat %0d",
                             got.value, $signed(got.seg), got.status, got.sat);
            end else begin
                want = expected_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                 want.value, $signed(want.seg), want.status, want.sat,
                                 got.value, $signed(got.seg), got.status, got.sat);
                end
            end
        end
    end

    // Hard limit on the whole run.
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_row       rows[$];
        t_row       r;
        t_plan_item it;
        t_interp    none;
        t_interp    empty_res;
        int         phase_count[12] = '{16, 16, 2, 2, 1, 0, 31, 7, 16, 20, 3, 12};
        bit         phase_angle[12] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 0};
        longint     step_max, t, off;
        int         k, nk;

        none = '{32'h0, 5'h0, plic_pkg::ST_INSIDE, 1'b0};
        empty_res = '{32'h0, 5'h1F, plic_pkg::ST_EMPTY, 1'b0};

        // Directed table. An empty table answers with status no-knots; a single
        // knot gives its own value below and above its time; the four-knot set
        // holds extreme times and values and a zero-width middle segment.
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h0, 1'b0, 5'd0), 1'b1, empty_res});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h7FFF_FFFF, 1'b1, 5'h0F), 1'b1,
                         empty_res});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, knot_wr(0, 32'h0, 32'h0), 1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, knot_wr(1, 32'h1_0000, 32'h7FFF_FFFF), 1'b0,
                         none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, knot_wr(2, 32'h1_0000, 32'd5), 1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, knot_wr(3, 32'h7FFF_FFFF, 32'h8000_0000),
                         1'b0, none});
        rows.push_back('{ROW_CFG, plic_pkg::CFG_KNOT_COUNT, 32'd1, query(0, 0, 0), 1'b0,
                         none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'hFFFF_FFFF, 1'b0, 5'd0), 1'b1,
                         '{32'h0, 5'h1F, plic_pkg::ST_BELOW, 1'b0}});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h0, 1'b0, 5'd0), 1'b1,
                         '{32'h0, 5'h0, plic_pkg::ST_ABOVE, 1'b0}});
        rows.push_back('{ROW_CFG, plic_pkg::CFG_ANGLE_MODE, 32'd1, query(0, 0, 0), 1'b0,
                         none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, knot_wr(0, 32'h8000_0000, 32'h7FFF_FFFF),
                         1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h8000_0000, 1'b0, 5'd0), 1'b0, none});
        rows.push_back('{ROW_CFG, plic_pkg::CFG_KNOT_COUNT, 32'd4, query(0, 0, 0), 1'b0,
                         none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h0, 1'b0, 5'd0), 1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h7FFF_FFFF, 1'b0, 5'd0), 1'b0, none});
        rows.push_back('{ROW_CFG, plic_pkg::CFG_ANGLE_MODE, 32'd0, query(0, 0, 0), 1'b0,
                         none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, knot_wr(0, 32'h0, 32'h0), 1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h8000_0000, 1'b0, 5'd0), 1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h8000, 1'b0, 5'd0), 1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h1_0000, 1'b0, 5'd0), 1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h7FFF_FFFF, 1'b0, 5'd0), 1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h4000, 1'b1, 5'h10), 1'b0, none});
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h4000, 1'b1, 5'h0F), 1'b0, none});
        // Hinted zero-width segment: the left knot's value, no clipping.
        rows.push_back('{ROW_ITEM, 8'd0, 32'd0, query(32'h4000, 1'b1, 5'd1), 1'b1,
                         '{32'h7FFF_FFFF, 5'd1, plic_pkg::ST_ZERO_W, 1'b0}});

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            r = rows[i];
            if (r.kind == ROW_CFG) begin
                drain();
                cfg_write(r.cfg_idx, r.cfg_data);
            end else begin
                send_item(r.it, r.typed, r.res);
            end
        end

        // Random phases: each loads a sorted table with random spacing, then
        // mixes queries near the knots with wild ones and a little noise.
        for (int p = 0; p < 12; p++) begin
            drain();
            tx_max = (p % 4 == 3) ? 0 : 5;
            rx_max = (p % 4 == 2) ? 0 : 5;
            // Upper data bits are random; the block keeps only the field width.
            cfg_write(plic_pkg::CFG_KNOT_COUNT,
                      {$urandom} & 32'hFFFF_FFE0 | 32'(phase_count[p]));
            cfg_write(plic_pkg::CFG_ANGLE_MODE,
                      {$urandom} & 32'hFFFF_FFFE | 32'(phase_angle[p]));
            step_max = $urandom_range(0, 1) ? 64'sd262144 : 64'sd67108864;
            t = -64'sd2147483648 + longint'($urandom_range(0, 32'h3FFF_FFFF));
            for (int sl = 0; sl < 16; sl++) begin
                // Roughly one segment in ten has zero width.
                if (sl > 0 && $urandom_range(0, 9) != 0)
                    t += longint'($urandom_range(1, int'(step_max)));
                if ($urandom_range(0, 1))
                    send_item(knot_wr(sl, t[31:0], $urandom), 1'b0, none);
                else
                    send_item(knot_wr(sl, t[31:0],
                                      32'($urandom_range(0, 8 * PI_Q) - 4 * PI_Q)),
                              1'b0, none);
            end
            // One long receiver hold-off while items keep coming.
            if (p == 1) long_hold_req = 400;
            nk = (phase_count[p] > 16) ? 16 : ((phase_count[p] == 0) ? 1 : phase_count[p]);
            for (int j = 0; j < 54; j++) begin
                k = $urandom_range(0, 99);
                if (k < 8) begin
                    send_item(knot_wr($urandom_range(0, 15), $urandom, $urandom), 1'b0, none);
                end else begin
                    if (k < 70) begin
                        off = longint'($urandom_range(0, 2 * int'(step_max))) - step_max;
                        off = knot_t[$urandom_range(0, nk - 1)] + off;
                        if (off > 64'sd2147483647) off = 64'sd2147483647;
                        if (off < -64'sd2147483648) off = -64'sd2147483648;
                        it = query(off[31:0], 1'b0, 5'($urandom));
                    end else begin
                        it = query($urandom, 1'b0, 5'($urandom));
                    end
                    it.use_hint = ($urandom_range(0, 3) == 0);
                    send_item(it, 1'b0, none);
                end
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
